[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared field widths, request codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_result;

endpackage

`default_nettype wire

[rtl/sts_table_ram.sv]
// ----------------------------------------------------------------------------
// Sorted table storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_table_ram
    import sts_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/sts_search.sv]
// ----------------------------------------------------------------------------
// Sorted table search controller
// Takes load and search transactions, runs one probe per cycle against the
// table RAM and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_search
    import sts_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_req_type,
    input  wire logic [POS_W-1:0]   i_load_position,
    input  wire logic [VALUE_W-1:0] i_load_value,
    input  wire logic [VALUE_W-1:0] i_search_key,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_result                 o_result,
    output logic                    o_mem_we,
    output logic      [AW-1:0]      o_mem_waddr,
    output logic      [VALUE_W-1:0] o_mem_wdata,
    output logic                    o_mem_re,
    output logic      [AW-1:0]      o_mem_raddr,
    input  wire logic [VALUE_W-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [COUNT_W-1:0]  r_count;
    logic [AW:0]         r_lo;
    logic [AW:0]         r_hi;
    logic [AW-1:0]       r_mid;
    logic signed [VALUE_W-1:0] r_key;
    t_result             r_res;
    logic                r_out_valid;
    t_result             r_out;

    logic                accept;
    logic [AW:0]         n_count;
    logic [AW:0]         n_lo;
    logic [AW:0]         n_hi;
    logic [AW+1:0]       mid_sum;
    logic [AW-1:0]       n_mid;
    logic                probe_eq;
    logic                probe_lt;
    logic                slot_free;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_ready;
    assign probe_eq  = ($signed(i_mem_rdata) == r_key);
    assign probe_lt  = ($signed(i_mem_rdata) < r_key);

    // count clamped to table depth
    always_comb begin
        if (32'(r_count) > 32'(DEPTH)) begin
            n_count = (AW+1)'(DEPTH);
        end else begin
            n_count = (AW+1)'(r_count);
        end
    end

    // next bounds: start of a search in idle, narrowing while searching
    always_comb begin
        if (r_state == S_IDLE) begin
            n_lo = '0;
            n_hi = n_count;
        end else if (probe_lt) begin
            n_lo = (AW+1)'(r_mid) + (AW+1)'(1);
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = (AW+1)'(r_mid);
        end
        mid_sum = (AW+2)'(n_lo) + (AW+2)'(n_hi) - (AW+2)'(1);
        n_mid   = mid_sum[AW:1];
    end

    always_comb begin
        o_mem_we    = accept && (i_req_type == REQ_LOAD) &&
                      (32'(i_load_position) < 32'(DEPTH));
        o_mem_waddr = AW'(i_load_position);
        o_mem_wdata = i_load_value;
        o_mem_raddr = n_mid;
        o_mem_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_mem_re = accept && (i_req_type == REQ_SEARCH) && (n_lo < n_hi);
            end
            S_SEARCH: begin
                o_mem_re = !probe_eq && (n_lo < n_hi);
            end
            default: begin
                o_mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if ((r_state == S_HOLD) && slot_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == REQ_SEARCH)) begin
                        r_key <= $signed(i_search_key);
                        r_lo  <= n_lo;
                        r_hi  <= n_hi;
                        r_mid <= n_mid;
                        if (n_lo < n_hi) begin
                            r_state <= S_SEARCH;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_SEARCH: begin
                    if (probe_eq) begin
                        r_res.found          <= 1'b1;
                        r_res.match_position <= POS_W'(r_mid);
                        r_state              <= S_HOLD;
                    end else if (n_lo < n_hi) begin
                        r_lo  <= n_lo;
                        r_hi  <= n_hi;
                        r_mid <= n_mid;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_probe_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((AW+1)'(r_mid) >= r_lo && (AW+1)'(r_mid) < r_hi))
        else $error("probe index outside search bounds");

    a_hi_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_hi <= n_count))
        else $error("upper bound beyond table count");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> !o_mem_re)
        else $error("table write and read in the same cycle");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.match_position == '0))
        else $error("miss result carries a nonzero position");

    a_result_after_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_HOLD))
        else $error("result issued outside hold state");

endmodule

`default_nettype wire

[rtl/sorted_table_binary_search.sv]
// Search: at most log2(TABLE_DEPTH) + 1 probes, each one table RAM read; the
// next transaction can be taken in the cycle that the result becomes valid.
// A load returns no result. An empty table answers without any probe.
// Reset (synchronous, active low) clears control and count_in_use to 0; the
// table contents are undefined until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Table of signed 32-bit entries with load and binary search transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,    // count_in_use
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [9:0] load_position, [41:10] load_value, [73:42] search_key, [79:74] zero
    input  wire logic [79:0]        s_axis_tdata,
    // [0] req_type
    input  wire logic [0:0]         s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [9:0] match_position, [15:10] zero
    output logic      [15:0]        m_axis_tdata,
    // [0] found
    output logic      [0:0]         m_axis_tuser
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    t_result            result;

    sts_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sts_search #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_req_type      (s_axis_tuser[0]),
        .i_load_position (s_axis_tdata[9:0]),
        .i_load_value    (s_axis_tdata[41:10]),
        .i_search_key    (s_axis_tdata[73:42]),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_result        (result),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    assign m_axis_tdata = {6'b0, result.match_position};
    assign m_axis_tuser = result.found;

endmodule

`default_nettype wire
